/* rtl/ccfd_pkg.sv */
`timescale 1ns / 1ps

package ccfd_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CFG_WIDTH = 16;
   localparam int PAYLOAD_LEN_WIDTH = 16;
   localparam int CRC_WIDTH = 32;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [BYTE_WIDTH-1:0] NO_ZERO_CODE = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] DELIMITER = 8'h00;
   localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 16'(2048 - 1);
   localparam int CRC_BYTES = 4;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_CRC_BAD  = 3'd2,
      KIND_GARBAGE  = 3'd3,
      KIND_OVERFLOW = 3'd4,
      KIND_EMPTY    = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [BYTE_WIDTH-1:0]          out_byte;
      logic [PAYLOAD_LEN_WIDTH-1:0]   payload_len;
   } result_type;

   // Reflected CRC-32, one byte, unrolled over its eight bits.
   function automatic logic [CRC_WIDTH-1:0] crc32_byte(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [BYTE_WIDTH-1:0] data);
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {CRC_WIDTH{c[0]}});
      end
      return c;
   endfunction

endpackage

/* rtl/cobs_crc_frame_decoder.sv */
`timescale 1ns / 1ps

// COBS frame decoder with CRC-32 check.
// req_ channel: one raw link byte per transfer (req_in_byte). Delimiter is 0x00.
// rsp_ channel: zero or one result per input byte. rsp_kind tells data byte,
//   frame good, crc bad, garbage abort, overflow abort or empty frame;
//   rsp_out_byte carries data bytes, rsp_payload_len the frame length less
//   the four CRC bytes at frame end.
// csr_ port: csr_wr_en writes csr_wr_data as the decoded length limit; write
//   only while no bytes are in flight.
// Path: a byte taken into the input register is decoded by ccfd_core and
//   loaded into the result register once that register is free; its result
//   is offered from the result register.
// Throughput: one byte per cycle while the receiver does not stall; the path
//   that sets the clock is the one-byte CRC-32 update plus the length compare in ccfd_core.
// Reset clears the frame state (no frame open, CRC all ones), sets the
//   limit to 2047 and drops anything held in the registers.
// When the receiver stalls, the result register holds and the input register
//   keeps its byte; req_stall rises only while both are occupied, so one
//   more byte is taken during a stall.
module cobs_crc_frame_decoder #(
   parameter int LEN_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [ccfd_pkg::BYTE_WIDTH-1:0]           req_in_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [2:0]                                rsp_kind,
   output logic [ccfd_pkg::BYTE_WIDTH-1:0]           rsp_out_byte,
   output logic [ccfd_pkg::PAYLOAD_LEN_WIDTH-1:0]    rsp_payload_len,
   input  logic                                      csr_wr_en,
   input  logic [ccfd_pkg::CFG_WIDTH-1:0]            csr_wr_data
);
   import ccfd_pkg::*;

   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic [CFG_WIDTH-1:0]  max_len_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;

   logic                  out_free;
   logic                  fire;
   logic                  res_valid;
   result_type            res;

   // result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   ccfd_core #(
      .LEN_BITS (LEN_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_payload_len = rsp_ff.payload_len;

endmodule

/* rtl/ccfd_core.sv */
`timescale 1ns / 1ps

module ccfd_core #(
   parameter int LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic [ccfd_pkg::BYTE_WIDTH-1:0]     in_byte,
   input  logic [ccfd_pkg::CFG_WIDTH-1:0]      max_len,
   output logic                                res_valid,
   output ccfd_pkg::result_type                res
);
   import ccfd_pkg::*;

   localparam int LIM_W = (LEN_BITS > CFG_WIDTH) ? LEN_BITS : CFG_WIDTH;
   localparam logic [LIM_W-1:0] LEN_MAX = LIM_W'({LEN_BITS{1'b1}});
   localparam logic [LIM_W-1:0] OUT_MAX = LIM_W'({PAYLOAD_LEN_WIDTH{1'b1}});

   logic [BYTE_WIDTH-1:0] last_code_ff, last_code_in;
   logic [BYTE_WIDTH-1:0] block_left_ff, block_left_in;
   logic [LEN_BITS-1:0]   count_ff, count_in;
   logic [CRC_WIDTH-1:0]  crc_ff, crc_in;

   logic [LIM_W-1:0]      limit;
   logic [LIM_W-1:0]      cfg_ext;
   logic [LIM_W-1:0]      count_ext;
   logic [LIM_W-1:0]      len_diff;
   logic                  overflow;
   logic                  byte_zero;
   // frame state as seen after a possible overflow reset
   logic [BYTE_WIDTH-1:0] lc;
   logic [BYTE_WIDTH-1:0] bl;
   logic [LEN_BITS-1:0]   cnt;
   logic [CRC_WIDTH-1:0]  crc;
   logic [BYTE_WIDTH-1:0] crc_data;
   logic [CRC_WIDTH-1:0]  crc_upd;
   logic [LEN_BITS-1:0]   cnt_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff  <= NO_ZERO_CODE;
         block_left_ff <= '0;
         count_ff      <= '0;
         crc_ff        <= CRC_INIT;
      end else begin
         last_code_ff  <= last_code_in;
         block_left_ff <= block_left_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
      end
   end

   always_comb begin
      cfg_ext   = LIM_W'(max_len);
      limit     = (cfg_ext > LEN_MAX) ? LEN_MAX : cfg_ext;
      count_ext = LIM_W'(count_ff);
      byte_zero = (in_byte == DELIMITER);
      overflow  = (count_ext >= limit) && !byte_zero;

      lc  = overflow ? NO_ZERO_CODE : last_code_ff;
      bl  = overflow ? '0 : block_left_ff;
      cnt = overflow ? '0 : count_ff;
      crc = overflow ? CRC_INIT : crc_ff;

      crc_data = (bl != '0) ? in_byte : DELIMITER;
      crc_upd  = crc32_byte(crc, crc_data);
      cnt_inc  = (cnt != {LEN_BITS{1'b1}}) ? cnt + 1'b1 : cnt;

      len_diff = (count_ext >= LIM_W'(CRC_BYTES)) ? count_ext - LIM_W'(CRC_BYTES) : '0;
      if (len_diff > OUT_MAX) begin
         len_diff = OUT_MAX;
      end

      last_code_in  = last_code_ff;
      block_left_in = block_left_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      res_valid     = 1'b0;
      res.kind        = KIND_DATA;
      res.out_byte    = '0;
      res.payload_len = '0;

      if (fire) begin
         last_code_in  = lc;
         block_left_in = bl;
         count_in      = cnt;
         crc_in        = crc;
         if (overflow) begin
            res_valid = 1'b1;
            res.kind  = KIND_OVERFLOW;
         end

         if (bl != '0) begin
            if (byte_zero) begin
               last_code_in  = NO_ZERO_CODE;
               block_left_in = '0;
               count_in      = '0;
               crc_in        = CRC_INIT;
               res_valid     = 1'b1;
               res.kind      = KIND_GARBAGE;
            end else begin
               crc_in        = crc_upd;
               count_in      = cnt_inc;
               block_left_in = bl - 1'b1;
               res_valid     = 1'b1;
               res.kind      = KIND_DATA;
               res.out_byte  = in_byte;
            end
         end else if (byte_zero) begin
            // delimiter: close the frame
            res_valid = 1'b1;
            if (count_ff == '0 && last_code_ff == NO_ZERO_CODE) begin
               res.kind = KIND_EMPTY;
            end else begin
               res.payload_len = PAYLOAD_LEN_WIDTH'(len_diff);
               if (count_ext < LIM_W'(CRC_BYTES) || crc_ff != '0) begin
                  res.kind = KIND_CRC_BAD;
               end else begin
                  res.kind = KIND_GOOD;
               end
            end
            last_code_in  = NO_ZERO_CODE;
            block_left_in = '0;
            count_in      = '0;
            crc_in        = CRC_INIT;
         end else begin
            // new block code; the implied zero of the previous block, if it has one, goes out now
            if (lc != NO_ZERO_CODE) begin
               crc_in       = crc_upd;
               count_in     = cnt_inc;
               res_valid    = 1'b1;
               res.kind     = KIND_DATA;
               res.out_byte = DELIMITER;
            end
            last_code_in  = in_byte;
            block_left_in = in_byte - 1'b1;
         end
      end
   end

endmodule

/* verif/tb_cobs_crc_frame_decoder.sv */
`timescale 1ns / 1ps

// Self-checking bench for the COBS frame decoder with CRC-32 check.
// - Short directed table first (reset limit, short/empty/good frames,
//   garbage and overflow aborts, limit 0/1/max), then random frames.
// - Random traffic: mostly well-formed COBS frames with random content, some
//   with a valid CRC tail, plus noise bursts and damaged frames.
// - A shadow decoder predicts every result transfer, except where a directed
//   row pins its own expectation; results are checked in order against it.
module tb_cobs_crc_frame_decoder;
   import ccfd_pkg::*;

   localparam int LEN_BITS = 16;
   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 7;
   // A code byte gives no result, so after the last result is back the bench
   // still waits before touching the limit register.
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENT_BYTES = 95;
   localparam int LONG_FRAME_LEN = 260;
   localparam int COBS_MAX_RUN = 254;

   typedef enum logic {ROW_BYTE, ROW_CFG} row_op_type;

   typedef struct {
      row_op_type               op;
      logic [CFG_WIDTH-1:0]     value;
      logic                     pinned;
      result_type               res;
   } stim_row_type;

   // ---------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ---------------------------------------------------------------
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [BYTE_WIDTH-1:0]         req_in_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [2:0]                    rsp_kind;
   logic [BYTE_WIDTH-1:0]         rsp_out_byte;
   logic [PAYLOAD_LEN_WIDTH-1:0]  rsp_payload_len;
   logic                          csr_wr_en = 1'b0;
   logic [CFG_WIDTH-1:0]          csr_wr_data = '0;

   // Hand-typed expectation riding along with the byte it belongs to.
   logic                          pin_valid = 1'b0;
   result_type                    pin_res = '0;

   // Shadow decoder state, starts at reset values
   logic [CFG_WIDTH-1:0]          limit_shadow = MAX_LEN_RESET;
   logic [BYTE_WIDTH-1:0]         code_shadow = NO_ZERO_CODE;
   logic [BYTE_WIDTH-1:0]         left_shadow = '0;
   logic [LEN_BITS-1:0]           count_shadow = '0;
   logic [CRC_WIDTH-1:0]          crc_shadow = CRC_INIT;

   result_type                    decode_queue[$];

   int errors = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int limit_writes = 0;
   int kind_seen[8];
   int tx_idle_pct = 9;
   int rx_idle_pct = 68;
   int hold_asked = 0;

   cobs_crc_frame_decoder #(.LEN_BITS(LEN_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_payload_len (rsp_payload_len),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow decoder
   // ---------------------------------------------------------------
   // Reflected CRC-32, bit at a time, LSB of the byte first.
   function automatic logic [CRC_WIDTH-1:0] crc_update(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [BYTE_WIDTH-1:0] b);
      logic [CRC_WIDTH-1:0] c;
      c = crc;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   task automatic restart_frame();
      code_shadow = NO_ZERO_CODE;
      left_shadow = '0;
      count_shadow = '0;
      crc_shadow = CRC_INIT;
   endtask

   // One decoded byte: fold into the CRC, count it (count saturates).
   task automatic absorb(input logic [BYTE_WIDTH-1:0] b);
      crc_shadow = crc_update(crc_shadow, b);
      if (count_shadow != {LEN_BITS{1'b1}}) count_shadow = count_shadow + 1'b1;
   endtask

   task automatic decode_predict(input logic [BYTE_WIDTH-1:0] b, output logic hit,
                                 output result_type res);
      longint limit;
      longint len;
      hit = 1'b0;
      res = '{kind: KIND_DATA, out_byte: '0, payload_len: '0};
      limit = limit_shadow;
      if (limit > (64'd1 << LEN_BITS) - 1) limit = (64'd1 << LEN_BITS) - 1;

      // Length limit: a nonzero byte at/over the limit aborts, then starts
      // a new frame as its first code byte.
      if (count_shadow >= limit && b != DELIMITER) begin
         restart_frame();
         hit = 1'b1;
         res = '{kind: KIND_OVERFLOW, out_byte: '0, payload_len: '0};
      end

      if (left_shadow != 0) begin
         if (b == DELIMITER) begin
            // zero inside a block: drop frame, zero is swallowed
            restart_frame();
            hit = 1'b1;
            res = '{kind: KIND_GARBAGE, out_byte: '0, payload_len: '0};
         end else begin
            absorb(b);
            left_shadow = left_shadow - 1'b1;
            hit = 1'b1;
            res = '{kind: KIND_DATA, out_byte: b, payload_len: '0};
         end
      end else if (b == DELIMITER) begin
         len = (count_shadow >= CRC_BYTES) ? count_shadow - CRC_BYTES : 0;
         if (len > 16'hFFFF) len = 16'hFFFF;
         hit = 1'b1;
         if (count_shadow == 0 && code_shadow == NO_ZERO_CODE)
            res = '{kind: KIND_EMPTY, out_byte: '0, payload_len: '0};
         else if (count_shadow < CRC_BYTES)
            res = '{kind: KIND_CRC_BAD, out_byte: '0, payload_len: 16'(len)};
         else if (crc_shadow == '0)
            res = '{kind: KIND_GOOD, out_byte: '0, payload_len: 16'(len)};
         else
            res = '{kind: KIND_CRC_BAD, out_byte: '0, payload_len: 16'(len)};
         restart_frame();
      end else begin
         // new block code; implied zero of the previous block unless it was 0xff
         if (code_shadow != NO_ZERO_CODE) begin
            absorb(DELIMITER);
            hit = 1'b1;
            res = '{kind: KIND_DATA, out_byte: DELIMITER, payload_len: '0};
         end
         code_shadow = b;
         left_shadow = b - 1'b1;
      end
   endtask

   // ---------------------------------------------------------------
   // Scoreboard: predict on byte transfer, check on result transfer,
   // watchdog on cycles with no transfer at all.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      logic       hit;
      result_type res;
      result_type want;
      int         idle_cycles;
      logic       moved;

      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         decode_predict(req_in_byte, hit, res);
         if (pin_valid) begin
            hit = 1'b1;
            res = pin_res;
         end
         if (hit) decode_queue.push_back(res);
         bytes_sent++;
         moved = 1'b1;
      end

      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         results_seen++;
         if (rsp_kind <= 3'd5) kind_seen[rsp_kind]++;
         if (decode_queue.size() == 0) begin
            $display("%0t unexpected result: expected none, actual kind %0d byte %02h len %0d",
                     $time, rsp_kind, rsp_out_byte, rsp_payload_len);
            errors++;
         end else begin
            want = decode_queue.pop_front();
            if (rsp_kind !== want.kind) begin
               $display("%0t kind mismatch: expected %0d, actual %0d",
                        $time, want.kind, rsp_kind);
               errors++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t out_byte mismatch: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_payload_len !== want.payload_len) begin
               $display("%0t payload_len mismatch: expected %0d, actual %0d",
                        $time, want.payload_len, rsp_payload_len);
               errors++;
            end
         end
      end

      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, decode_queue.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stall, or a long hold-off when one is asked for.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : receiver
      int hold_left;
      int hold_done;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_done != hold_asked) begin
         hold_done++;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // Offer one byte, with random idle cycles ahead of it; returns at the
   // edge where the transfer happens.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic pin,
                            input result_type pres);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      pin_valid <= pin;
      pin_res <= pres;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering, wait for every outstanding result, then let any byte
   // that yields no result clear the pipe.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (decode_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_WIDTH-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_shadow = v;
      limit_writes++;
   endtask

   // Build a random payload, optionally append its CRC (LSB first so the
   // residue ends at zero), COBS-encode, optionally damage, add delimiter.
   task automatic send_frame(input int len, input int zero_pct, input bit with_crc,
                             input bit damage);
      logic [BYTE_WIDTH-1:0] raw[$];
      logic [BYTE_WIDTH-1:0] enc[$];
      logic [BYTE_WIDTH-1:0] run[$];
      logic [BYTE_WIDTH-1:0] b;
      logic [CRC_WIDTH-1:0]  crc;
      int                    pos;
      crc = CRC_INIT;
      for (int i = 0; i < len; i++) begin
         b = ($urandom_range(99) < zero_pct) ? DELIMITER : 8'($urandom_range(1, 255));
         raw.push_back(b);
         crc = crc_update(crc, b);
      end
      if (with_crc)
         for (int k = 0; k < CRC_BYTES; k++) raw.push_back(crc[8*k +: 8]);

      foreach (raw[j]) begin
         if (raw[j] == DELIMITER) begin
            enc.push_back(8'(run.size() + 1));
            foreach (run[m]) enc.push_back(run[m]);
            run.delete();
         end else begin
            run.push_back(raw[j]);
            // full run: 0xff block, no implied zero after it
            if (run.size() == COBS_MAX_RUN) begin
               enc.push_back(NO_ZERO_CODE);
               foreach (run[m]) enc.push_back(run[m]);
               run.delete();
            end
         end
      end
      enc.push_back(8'(run.size() + 1));
      foreach (run[m]) enc.push_back(run[m]);

      if (damage) begin
         pos = $urandom_range(enc.size() - 1);
         if ($urandom_range(1)) enc[pos] = ($urandom_range(1)) ? DELIMITER
                                                             : 8'($urandom_range(255));
         else enc.delete(pos);
      end
      enc.push_back(DELIMITER);
      foreach (enc[j]) send_byte(enc[j], 1'b0, '0);
   endtask

   function automatic stim_row_type row_byte(input logic [BYTE_WIDTH-1:0] b);
      return '{op: ROW_BYTE, value: CFG_WIDTH'(b), pinned: 1'b0, res: '0};
   endfunction

   function automatic stim_row_type row_pin(input logic [BYTE_WIDTH-1:0] b, input kind_type k,
                                            input logic [BYTE_WIDTH-1:0] ob,
                                            input logic [PAYLOAD_LEN_WIDTH-1:0] len);
      return '{op: ROW_BYTE, value: CFG_WIDTH'(b), pinned: 1'b1,
               res: '{kind: k, out_byte: ob, payload_len: len}};
   endfunction

   function automatic stim_row_type row_cfg(input logic [CFG_WIDTH-1:0] v);
      return '{op: ROW_CFG, value: v, pinned: 1'b0, res: '0};
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      stim_row_type          rows[$];
      logic [CFG_WIDTH-1:0]  limits[6];
      int                    tx_pcts[3];
      int                    rx_pcts[3];
      int                    target;
      int                    frames;
      int                    pick;
      int                    len;
      int                    zpct;
      int                    room;

      rows = {
         // reset limit 2047; bare delimiter is an empty frame
         row_pin(8'h00, KIND_EMPTY, 8'h00, 16'd0),
         // code byte only, then delimiter: short frame, no implied zero
         row_byte(8'h01),
         row_pin(8'h00, KIND_CRC_BAD, 8'h00, 16'd0),
         // FF FF FF FF after an all-ones CRC leaves residue zero
         row_byte(8'h05),
         row_pin(8'hFF, KIND_DATA, 8'hFF, 16'd0),
         row_pin(8'hFF, KIND_DATA, 8'hFF, 16'd0),
         row_pin(8'hFF, KIND_DATA, 8'hFF, 16'd0),
         row_pin(8'hFF, KIND_DATA, 8'hFF, 16'd0),
         row_pin(8'h00, KIND_GOOD, 8'h00, 16'd0),
         // implied zero shows up at the next code byte
         row_byte(8'h02),
         row_byte(8'h80),
         row_pin(8'h01, KIND_DATA, 8'h00, 16'd0),
         row_pin(8'h00, KIND_CRC_BAD, 8'h00, 16'd0),
         // zero inside a block
         row_byte(8'h03),
         row_byte(8'h55),
         row_pin(8'h00, KIND_GARBAGE, 8'h00, 16'd0),
         // limit 0: any nonzero byte overflows, then opens a new frame
         row_cfg(16'd0),
         row_pin(8'h05, KIND_OVERFLOW, 8'h00, 16'd0),
         row_pin(8'h00, KIND_GARBAGE, 8'h00, 16'd0),
         row_pin(8'h00, KIND_EMPTY, 8'h00, 16'd0),
         // limit 1
         row_cfg(16'd1),
         row_byte(8'h02),
         row_pin(8'h41, KIND_DATA, 8'h41, 16'd0),
         row_pin(8'h07, KIND_OVERFLOW, 8'h00, 16'd0),
         row_pin(8'h00, KIND_GARBAGE, 8'h00, 16'd0),
         // limit at max
         row_cfg(16'hFFFF),
         row_pin(8'h00, KIND_EMPTY, 8'h00, 16'd0),
         row_byte(8'hFE),
         row_pin(8'h00, KIND_GARBAGE, 8'h00, 16'd0)
      };

      limits = '{16'd300, 16'd5, 16'hFFFF, 16'd1, 16'd0, 16'd40};
      limits[4] = 16'($urandom_range(1, 65535));
      tx_pcts = '{9, 68, 0};
      rx_pcts = '{68, 9, 0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         if (rows[i].op == ROW_CFG) begin
            settle();
            write_limit(rows[i].value);
         end else begin
            send_byte(rows[i].value[BYTE_WIDTH-1:0], rows[i].pinned, rows[i].res);
         end
      end

      // random frames: three idle profiles, two limit settings each
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = tx_pcts[phase];
         rx_idle_pct = rx_pcts[phase];
         for (int seg = 0; seg < 2; seg++) begin
            // sender pauses here until every result is back
            settle();
            write_limit(limits[phase * 2 + seg]);
            target = bytes_sent + SEGMENT_BYTES;
            frames = 0;
            while (bytes_sent < target) begin
               // long receiver hold-off while bytes keep coming: fills the pipe
               if (seg == 0 && frames == 0) hold_asked++;
               pick = $urandom_range(99);
               len = $urandom_range(99);
               if (len < 70) len = $urandom_range(0, 24);
               else if (len < 90) len = $urandom_range(25, 80);
               else len = $urandom_range(250, 600);  // cut below to what is left
               zpct = $urandom_range(2);
               zpct = (zpct == 0) ? 0 : (zpct == 1) ? 5 : 30;
               // keep the segment near its byte budget
               room = target - bytes_sent - CRC_BYTES - 2;
               if (len > room) len = (room > 0) ? room : 0;
               // one long zero-free frame under the widest limit: 0xff blocks
               if (phase == 1 && seg == 0 && frames == 0) begin
                  pick = 0;
                  len = LONG_FRAME_LEN;
                  zpct = 0;
               end
               if (pick < 80) begin
                  send_frame(len, zpct, $urandom_range(99) < 70, 1'b0);
               end else if (pick < 90) begin
                  repeat ($urandom_range(1, 8))
                     send_byte(($urandom_range(3) == 0) ? DELIMITER : 8'($urandom_range(255)),
                               1'b0, '0);
               end else begin
                  send_frame(len, zpct, 1'b1, 1'b1);
               end
               frames++;
            end
         end
      end

      settle();
      $display("Covered %0d byte transfers and %0d result transfers over %0d limit settings.",
               bytes_sent, results_seen, limit_writes);
      $display("Results: %0d data, %0d good, %0d crc bad, %0d garbage, %0d overflow, %0d empty.",
               kind_seen[KIND_DATA], kind_seen[KIND_GOOD], kind_seen[KIND_CRC_BAD],
               kind_seen[KIND_GARBAGE], kind_seen[KIND_OVERFLOW], kind_seen[KIND_EMPTY]);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ccfd_pkg.sv
rtl/ccfd_core.sv
rtl/cobs_crc_frame_decoder.sv
verif/tb_cobs_crc_frame_decoder.sv
